FILE: rtl/multi_queue_linked_fifo_top_defines.svh
// assertion macros for the linked multi-queue fifo checker
// no dependencies
`ifndef MULTI_QUEUE_LINKED_FIFO_TOP_DEFINES_SVH
`define MULTI_QUEUE_LINKED_FIFO_TOP_DEFINES_SVH

// clocked assertion, disabled while reset is high
`define MQLF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same, on the block clock and reset
`define MQLF_ASSERT_CLK(name, prop, msg) \
   `MQLF_ASSERT(name, clock, reset, prop, msg)

`endif

FILE: rtl/mqlf_pkg.sv
// shared types and codes for the linked multi-queue fifo
// no dependencies
package mqlf_pkg;

   localparam int QIDX_WIDTH     = 4;
   localparam int STATUS_WIDTH   = 2;
   localparam int KEY_PORT_WIDTH = 32;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } ctl_cmd_type;

endpackage

FILE: rtl/mqlf_ctrl.sv
// sequencing state machine for the linked multi-queue fifo
// depends on mqlf_pkg
module mqlf_ctrl import mqlf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        out_free,
   output logic        req_stall,
   output ctl_cmd_type cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.commit = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/mqlf_dp.sv
// pointer registers, node memories and result register of the linked multi-queue fifo
// depends on mqlf_pkg
module mqlf_dp import mqlf_pkg::*; #(
   parameter int NUM_QUEUES = 10,
   parameter int POOL_DEPTH = 256,
   parameter int KEY_WIDTH  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ctl_cmd_type                      cmd,
   input  logic                             req_operation,
   input  logic [QIDX_WIDTH-1:0]            req_queue_index,
   input  logic signed [KEY_PORT_WIDTH-1:0] req_key_in,
   input  logic                             rsp_stall,
   output logic                             out_free,
   output logic                             rsp_valid,
   output logic [STATUS_WIDTH-1:0]          rsp_status,
   output logic signed [KEY_PORT_WIDTH-1:0] rsp_key_out
);

   localparam int PW = $clog2(POOL_DEPTH);
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int IW = (QW > QIDX_WIDTH) ? QW : QIDX_WIDTH;
   localparam int SW = (KEY_WIDTH < KEY_PORT_WIDTH) ? KEY_WIDTH : KEY_PORT_WIDTH;
   localparam logic [PW-1:0] LAST_NODE  = PW'(POOL_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(POOL_DEPTH);

   logic                  op_ff;
   logic [QIDX_WIDTH-1:0] q_ff;
   logic [SW-1:0]         key_ff;

   logic [PW-1:0]         head_ff [NUM_QUEUES];
   logic [PW-1:0]         tail_ff [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] nonempty_ff, nonempty_in;
   logic [PW-1:0]         free_head_ff, free_head_in;
   logic [CW-1:0]         free_count_ff, free_count_in;
   logic [CW-1:0]         fresh_ff, fresh_in;

   logic [PW-1:0]         node_ff;
   logic [SW-1:0]         rd_key_ff;
   logic [PW-1:0]         rd_next_ff;
   logic                  unwritten_ff;
   logic                  reject_ff;

   logic [SW-1:0]         key_mem  [POOL_DEPTH];
   logic [PW-1:0]         next_mem [POOL_DEPTH];

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0]          rsp_status_ff;
   logic signed [KEY_PORT_WIDTH-1:0] rsp_key_ff;

   logic [IW-1:0] q_ext;
   logic [QW-1:0] qi;
   logic          in_range;
   logic          is_append;
   logic [PW-1:0] lookup_addr;
   logic          reject;
   logic [PW-1:0] succ_node;
   logic [PW-1:0] next_val;
   logic          do_append;
   logic          do_remove;
   logic          next_wr_en;
   logic [PW-1:0] next_wr_addr;
   logic [PW-1:0] next_wr_data;

   assign q_ext     = IW'(q_ff);
   assign qi        = q_ext[QW-1:0];
   assign in_range  = ({1'b0, q_ext} < (IW + 1)'(NUM_QUEUES));
   assign is_append = (op_ff == OP_APPEND);

   assign lookup_addr = is_append ? free_head_ff : head_ff[qi];
   assign reject      = !in_range ||
                        (is_append ? (free_count_ff == '0) : !nonempty_ff[qi]);

   assign succ_node = (node_ff == LAST_NODE) ? '0 : node_ff + PW'(1);
   assign next_val  = unwritten_ff ? succ_node : rd_next_ff;

   assign do_append = cmd.commit && !reject_ff && is_append;
   assign do_remove = cmd.commit && !reject_ff && !is_append;

   assign next_wr_en   = do_remove || (do_append && nonempty_ff[qi]);
   assign next_wr_addr = do_remove ? node_ff : tail_ff[qi];
   assign next_wr_data = do_remove ? free_head_ff : node_ff;

   // captured word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         q_ff   <= req_queue_index;
         key_ff <= req_key_in[SW-1:0];
      end
   end

   // lookup results
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         node_ff      <= lookup_addr;
         reject_ff    <= reject;
         unwritten_ff <= (CW'(lookup_addr) >= fresh_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (do_append) begin
         key_mem[node_ff] <= key_ff;
      end
      if (cmd.lookup) begin
         rd_key_ff <= key_mem[lookup_addr];
      end
   end

   // nodes at or above the fill mark were never written; their link is taken as the next node
   always_ff @(posedge clock) begin
      if (next_wr_en) begin
         next_mem[next_wr_addr] <= next_wr_data;
      end
      if (cmd.lookup) begin
         rd_next_ff <= next_mem[lookup_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (do_append) begin
         if (!nonempty_ff[qi]) begin
            head_ff[qi] <= node_ff;
         end
         tail_ff[qi] <= node_ff;
      end else if (do_remove && (node_ff != tail_ff[qi])) begin
         head_ff[qi] <= next_val;
      end
   end

   always_comb begin
      nonempty_in   = nonempty_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      fresh_in      = fresh_ff;
      if (do_append) begin
         nonempty_in[qi] = 1'b1;
         free_head_in    = next_val;
         free_count_in   = free_count_ff - CW'(1);
         if (unwritten_ff) begin
            fresh_in = fresh_ff + CW'(1);
         end
      end else if (do_remove) begin
         if (node_ff == tail_ff[qi]) begin
            nonempty_in[qi] = 1'b0;
         end
         free_head_in = node_ff;
         if (free_count_ff < FULL_COUNT) begin
            free_count_in = free_count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff   <= '0;
         free_head_ff  <= '0;
         free_count_ff <= FULL_COUNT;
         fresh_ff      <= '0;
      end else begin
         nonempty_ff   <= nonempty_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         fresh_ff      <= fresh_in;
      end
   end

   // result register
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (reject_ff) begin
            rsp_status_ff <= is_append ? STATUS_FULL : STATUS_EMPTY;
         end else begin
            rsp_status_ff <= STATUS_DONE;
         end
         rsp_key_ff <= do_remove ? KEY_PORT_WIDTH'(rd_key_ff) : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_key_out = rsp_key_ff;

endmodule

FILE: rtl/multi_queue_linked_fifo_top.sv
// linked multi-queue fifo: a word is taken, looked up in the pointer registers and node
// memories, then committed; the result is registered at the commit.
// a new word is taken only in idle, once the last one is committed; the node memories
// are read registered between lookup and commit; a stalled result holds the commit step.
// synchronous reset clears queue flags, free list head and fill mark and sets the free count to the pool depth;
// no memory clearing pass, nodes at or above the fill mark take the next node as their link.
module multi_queue_linked_fifo_top import mqlf_pkg::*; #(
   parameter int NUM_QUEUES = 10,
   parameter int POOL_DEPTH = 256,
   parameter int KEY_WIDTH  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_operation,
   input  logic [QIDX_WIDTH-1:0]            req_queue_index,
   input  logic signed [KEY_PORT_WIDTH-1:0] req_key_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [STATUS_WIDTH-1:0]          rsp_status,
   output logic signed [KEY_PORT_WIDTH-1:0] rsp_key_out
);

   ctl_cmd_type cmd;
   logic        out_free;

   mqlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   mqlf_dp #(
      .NUM_QUEUES (NUM_QUEUES),
      .POOL_DEPTH (POOL_DEPTH),
      .KEY_WIDTH  (KEY_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_queue_index (req_queue_index),
      .req_key_in      (req_key_in),
      .rsp_stall       (rsp_stall),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_key_out     (rsp_key_out)
   );

endmodule

FILE: rtl/mqlf_chk.sv
// port-level checker for the linked multi-queue fifo, bound to the top level
// depends on mqlf_pkg and multi_queue_linked_fifo_top_defines.svh
`include "multi_queue_linked_fifo_top_defines.svh"

module mqlf_chk import mqlf_pkg::*; (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [STATUS_WIDTH-1:0]          rsp_status,
   input logic signed [KEY_PORT_WIDTH-1:0] rsp_key_out
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   `MQLF_ASSERT_CLK(a_busy_after_take, req_take |=> req_stall, "stall not raised after a word")
   `MQLF_ASSERT_CLK(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_key_out)), "stalled result changed")
   `MQLF_ASSERT_CLK(a_rsp_from_req, $rose(rsp_valid) |-> $past(req_take, 3), "result without a word three edges earlier")
   `MQLF_ASSERT_CLK(a_status_code, rsp_valid |-> (rsp_status == STATUS_DONE || rsp_status == STATUS_EMPTY || rsp_status == STATUS_FULL), "bad status code")
   `MQLF_ASSERT_CLK(a_reject_key_zero, (rsp_valid && rsp_status != STATUS_DONE) |-> (rsp_key_out == '0), "rejected word returned a key")

endmodule

bind multi_queue_linked_fifo_top mqlf_chk u_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_key_out     (rsp_key_out)
);

FILE: tb/tb_multi_queue_linked_fifo_top.sv
// testbench for multi_queue_linked_fifo_top: appends and removes keys on ten queues
// sharing one node pool, checks every result word against a local queue pool model
// depends on mqlf_pkg and the rtl of multi_queue_linked_fifo_top
`timescale 1ns / 1ps

module tb_multi_queue_linked_fifo_top;
   import mqlf_pkg::*;

   localparam int QUIET_LIMIT = 1000;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]   status;
      logic [KEY_PORT_WIDTH-1:0] key;
   } result_word_type;

   class queue_pool_model;
      localparam int NQ   = 10;
      localparam int POOL = 256;

      int head [NQ];
      int tail [NQ];
      bit busy [NQ];
      logic [KEY_PORT_WIDTH-1:0] key_mem [POOL];
      int link [POOL];
      int free_head;
      int free_count;
      int errors;
      result_word_type owed_results [$];

      function new();
         for (int i = 0; i < NQ; i++) begin
            head[i] = 0;
            tail[i] = 0;
            busy[i] = 0;
         end
         for (int n = 0; n < POOL; n++) begin
            link[n] = (n + 1) % POOL;
         end
         free_head = 0;
         free_count = POOL;
         errors = 0;
      endfunction

      function void take_word(logic op, logic [QIDX_WIDTH-1:0] q,
                              logic [KEY_PORT_WIDTH-1:0] key);
         result_word_type r;
         int node;
         r.status = STATUS_DONE;
         r.key = '0;
         if (op == OP_APPEND) begin
            if (q >= NQ || free_count == 0) begin
               r.status = STATUS_FULL;
            end else begin
               node = free_head;
               free_head = link[node];
               free_count--;
               key_mem[node] = key;
               if (busy[q]) link[tail[q]] = node;
               else head[q] = node;
               tail[q] = node;
               busy[q] = 1;
            end
         end else begin
            if (q >= NQ || !busy[q]) begin
               r.status = STATUS_EMPTY;
            end else begin
               node = head[q];
               r.key = key_mem[node];
               if (node == tail[q]) busy[q] = 0;
               else head[q] = link[node];
               link[node] = free_head;
               free_head = node;
               if (free_count < POOL) free_count++;
            end
         end
         owed_results.push_back(r);
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_word(logic [STATUS_WIDTH-1:0] status, logic [KEY_PORT_WIDTH-1:0] key);
         result_word_type r;
         if (owed_results.size() == 0) begin
            report($sformatf("unexpected result word status %0d key %h", status, key));
         end else begin
            r = owed_results.pop_front();
            if (status !== r.status)
               report($sformatf("status %0d, wanted %0d", status, r.status));
            if (key !== r.key)
               report($sformatf("key %h, wanted %h", key, r.key));
         end
      endtask
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_operation = OP_APPEND;
   logic [QIDX_WIDTH-1:0]            req_queue_index = '0;
   logic signed [KEY_PORT_WIDTH-1:0] req_key_in = '0;
   logic                             rsp_stall = 1'b0;
   logic                             req_stall;
   logic                             rsp_valid;
   logic [STATUS_WIDTH-1:0]          rsp_status;
   logic signed [KEY_PORT_WIDTH-1:0] rsp_key_out;

   queue_pool_model model;
   int send_idle = 0;
   int recv_stall = 0;
   int phase = 0;
   int hold_left = 0;
   bit pressure_done = 0;
   int quiet_cycles = 0;

   multi_queue_linked_fifo_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_queue_index (req_queue_index),
      .req_key_in      (req_key_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_key_out     (rsp_key_out)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task send_word(input logic op, input logic [QIDX_WIDTH-1:0] q,
                  input logic [KEY_PORT_WIDTH-1:0] key);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_queue_index <= q;
      req_key_in <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model.take_word(op, q, key);
   endtask

   task random_word(input int append_pct);
      logic op;
      logic [QIDX_WIDTH-1:0] q;
      op = ($urandom_range(99) < append_pct) ? OP_APPEND : OP_REMOVE;
      if ($urandom_range(99) < 4) q = QIDX_WIDTH'($urandom_range(15, 10));
      else q = QIDX_WIDTH'($urandom_range(9, 0));
      send_word(op, q, $urandom());
   endtask

   // result side: check accepted words, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) model.check_word(rsp_status, rsp_key_out);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (phase == 2 && !pressure_done) begin
         hold_left = 150;
         pressure_done = 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int idle_tab [4];
      int stall_tab [4];
      int append_tab [4];
      int count_tab [4];
      idle_tab = '{0, 60, 0, 16};
      stall_tab = '{0, 0, 60, 16};
      append_tab = '{95, 95, 15, 50};
      count_tab = '{170, 170, 170, 160};
      model = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue, extreme keys, out of range queues, single key queue end
      send_word(OP_REMOVE, 4'd0, 32'h0000_0000);
      send_word(OP_APPEND, 4'd0, 32'h7fff_ffff);
      send_word(OP_APPEND, 4'd0, 32'h8000_0000);
      send_word(OP_APPEND, 4'd9, 32'hffff_ffff);
      send_word(OP_APPEND, 4'd9, 32'h0000_0000);
      send_word(OP_APPEND, 4'd10, 32'h0000_0005);
      send_word(OP_APPEND, 4'd15, 32'h1234_5678);
      send_word(OP_REMOVE, 4'd15, 32'hffff_ffff);
      send_word(OP_REMOVE, 4'd10, 32'h0000_0000);
      send_word(OP_REMOVE, 4'd0, 32'hffff_ffff);
      send_word(OP_REMOVE, 4'd0, 32'h0000_0000);
      send_word(OP_REMOVE, 4'd0, 32'h0000_0000);
      send_word(OP_REMOVE, 4'd9, 32'h0000_0000);
      send_word(OP_REMOVE, 4'd9, 32'h0000_0000);
      send_word(OP_APPEND, 4'd5, 32'h5555_5555);
      send_word(OP_REMOVE, 4'd5, 32'haaaa_aaaa);
      send_word(OP_APPEND, 4'd5, 32'haaaa_aaaa);
      send_word(OP_APPEND, 4'd5, 32'h0000_0001);
      send_word(OP_REMOVE, 4'd5, 32'h0000_0000);
      send_word(OP_REMOVE, 4'd5, 32'h0000_0000);

      // fill the pool past full, then a remove-heavy phase with a held result stall, then a mixed phase
      for (int p = 0; p < 4; p++) begin
         send_idle = idle_tab[p];
         recv_stall = stall_tab[p];
         phase = p;
         repeat (count_tab[p]) random_word(append_tab[p]);
      end
      req_valid <= 1'b0;

      while (model.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (model.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
